/* src/bsdc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the bounded sorted collector.
// Used by bsdc_cell and bounded_sorted_dedup_collector; depends on nothing.
package bsdc_pkg;

   localparam int CAPACITY  = 16;
   localparam int ID_WORDS  = 4;
   localparam int IN_WORDS  = 4;
   localparam int CNT_W     = $clog2(CAPACITY + 1);
   localparam int CAP_RESET = (CAPACITY < 16) ? CAPACITY : 16;
   localparam int CFG_CAP_W = 5;
   localparam int CSR_IDX_W = 4;

   localparam logic [CSR_IDX_W-1:0] CSR_SINCE_TIME = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CAPACITY   = CSR_IDX_W'(1);

   localparam logic [2:0] STATUS_INSERTED  = 3'd0;
   localparam logic [2:0] STATUS_DUPLICATE = 3'd1;
   localparam logic [2:0] STATUS_FULL      = 3'd2;
   localparam logic [2:0] STATUS_FILTERED  = 3'd3;
   localparam logic [2:0] STATUS_DRAINED   = 3'd4;
   localparam logic [2:0] STATUS_EMPTY     = 3'd5;

   typedef struct packed {
      logic        mode;
      logic        is_confirmed;
      logic [63:0] timestamp;
      logic [63:0] id_word0;
      logic [63:0] id_word1;
      logic [63:0] id_word2;
      logic [63:0] id_word3;
      logic [15:0] record_tag;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [63:0] out_timestamp;
      logic [63:0] out_id_word0;
      logic [63:0] out_id_word1;
      logic [63:0] out_id_word2;
      logic [63:0] out_id_word3;
      logic [15:0] out_tag;
      logic [63:0] newest_time;
      logic        last;
   } rsp_type;

   // word 0 is leftmost, so the packed id compares as one big-endian number
   typedef struct packed {
      logic [63:0]                    stamp;
      logic [0:ID_WORDS-1][63:0]      id;
      logic [15:0]                    tag;
   } entry_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_CMP,
      CELL_INS,
      CELL_SHIFT
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      logic        held;
   } cell_ctrl_type;

   typedef struct packed {
      logic dup;
      logic keep;
   } cell_flag_type;

endpackage

/* src/bsdc_cell.sv */
`timescale 1ns / 1ps
// One slot of the sorted chain: holds an entry, compares it with the candidate,
// shifts right on insertion and left on drain. Depends on bsdc_pkg.
module bsdc_cell import bsdc_pkg::*; (
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  entry_type     cand,
   input  entry_type     left_entry,
   input  logic          left_keep,
   input  entry_type     right_entry,
   output entry_type     entry,
   output cell_flag_type flags
);

   entry_type     entry_ff, entry_in;
   cell_flag_type flags_ff, flags_in;
   logic          le_cand;
   logic          same_id;

   always_comb begin
      same_id  = (entry_ff.id == cand.id);
      le_cand  = (entry_ff.stamp < cand.stamp) ||
                 ((entry_ff.stamp == cand.stamp) && (entry_ff.id <= cand.id));
      entry_in = entry_ff;
      flags_in = flags_ff;
      unique case (ctrl.op)
         CELL_HOLD: begin
         end
         CELL_CMP: begin
            flags_in.dup  = ctrl.held && same_id;
            flags_in.keep = ctrl.held && le_cand;
         end
         CELL_INS: begin
            if (!flags_ff.keep) begin
               entry_in = left_keep ? cand : left_entry;
            end
         end
         CELL_SHIFT: begin
            entry_in = right_entry;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      flags_ff <= flags_in;
   end

   assign entry = entry_ff;
   assign flags = flags_ff;

endmodule

/* src/bounded_sorted_dedup_collector.sv */
`timescale 1ns / 1ps
// Bounded sorted collector with duplicate suppression: control and the cell chain.
// Depends on bsdc_pkg and bsdc_cell.
//
// Use: raise start with a word on req_data; it is taken at an edge where busy is low.
// An offer (mode 0) yields one result word; a drain (mode 1) yields one word per held
// entry in ascending order, or a single drain-empty word, then clears the list.
// Results appear on rsp_data for one cycle each, flagged by rsp_valid, last set on the
// final word of an item. The receiver cannot stall; no word is ever held back.
// Timing: an item is compared in every cell of the chain in the cycle after it is
// taken and decided in the next; an offer result is registered in the decide state,
// and no new item is taken until the block is back in idle. A drain of n entries
// shifts the chain one slot per cycle, one result word per slot, then goes idle.
// Registers: csr_index 0 is since_time, 1 is capacity (saturated to the chain length,
// lowering it drops entries beyond it). csr_ready is always high; write only while idle.
// Reset: list empty, since_time 0, capacity 16; stored entries stay undefined.
module bounded_sorted_dedup_collector import bsdc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  req_type              req_data,
   output logic                 rsp_valid,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CMP    = 4'b0010,
      ST_DECIDE = 4'b0100,
      ST_DRAIN  = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   req_type          req_ff, req_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] remain_ff, remain_in;
   logic [63:0]      since_ff, since_in;
   logic [63:0]      newest_ff, newest_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   entry_type        cand;
   cell_op_type      cell_op;
   cell_ctrl_type    cell_ctrl  [CAPACITY];
   entry_type        cell_entry [CAPACITY];
   cell_flag_type    cell_flags [CAPACITY];
   entry_type        left_e     [CAPACITY];
   logic             left_k     [CAPACITY];
   entry_type        right_e    [CAPACITY];
   logic [CAPACITY-1:0] dup_vec, keep_vec, slot_last, tail_vec;

   logic [IN_WORDS-1:0][63:0] req_words;
   logic [IN_WORDS-1:0][63:0] out_words;
   logic [63:0]      tail_stamp;
   logic             filtered, dup_any, reject;
   logic [CFG_CAP_W-1:0] cap_raw;
   logic [CNT_W-1:0] cap_eff;

   always_comb begin
      req_words = {req_ff.id_word3, req_ff.id_word2, req_ff.id_word1, req_ff.id_word0};
      cand       = '0;
      cand.stamp = req_ff.timestamp;
      cand.tag   = req_ff.record_tag;
      for (int w = 0; w < ID_WORDS; w++) begin
         cand.id[w] = req_words[w];
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign cell_ctrl[i].op   = cell_op;
      assign cell_ctrl[i].held = (count_ff > CNT_W'(i));
      assign dup_vec[i]   = cell_flags[i].dup;
      assign keep_vec[i]  = cell_flags[i].keep;
      assign slot_last[i] = (cap_ff == CNT_W'(i + 1));
      assign tail_vec[i]  = (count_ff == CNT_W'(i + 1));
      if (i == 0) begin : g_head
         assign left_e[i] = cand;
         assign left_k[i] = 1'b1;
      end else begin : g_body
         assign left_e[i] = cell_entry[i-1];
         assign left_k[i] = cell_flags[i-1].keep;
      end
      if (i == CAPACITY - 1) begin : g_tail
         assign right_e[i] = '0;
      end else begin : g_inner
         assign right_e[i] = cell_entry[i+1];
      end
      bsdc_cell u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl[i]),
         .cand        (cand),
         .left_entry  (left_e[i]),
         .left_keep   (left_k[i]),
         .right_entry (right_e[i]),
         .entry       (cell_entry[i]),
         .flags       (cell_flags[i])
      );
   end

   always_comb begin
      tail_stamp = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tail_stamp = tail_stamp | (tail_vec[i] ? cell_entry[i].stamp : 64'd0);
      end
      out_words = '0;
      for (int w = 0; w < ID_WORDS; w++) begin
         out_words[w] = cell_entry[0].id[w];
      end
      filtered = !req_ff.is_confirmed || (req_ff.timestamp <= since_ff);
      dup_any  = |dup_vec;
      reject   = (cap_ff == '0) || (|(keep_vec & slot_last));
      cap_raw  = csr_wdata[CFG_CAP_W-1:0];
      cap_eff  = (32'(cap_raw) > CAPACITY) ? CNT_W'(CAPACITY) : CNT_W'(cap_raw);
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      cap_in       = cap_ff;
      since_in     = since_ff;
      remain_in    = remain_ff;
      newest_in    = newest_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      cell_op      = CELL_HOLD;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            cell_op   = CELL_CMP;
            newest_in = (tail_stamp > since_ff) ? tail_stamp : since_ff;
            state_in  = ST_DECIDE;
         end
         ST_DECIDE: begin
            rsp_in      = '0;
            rsp_in.last = 1'b1;
            state_in    = ST_IDLE;
            if (req_ff.mode) begin
               if (count_ff == '0) begin
                  rsp_valid_in       = 1'b1;
                  rsp_in.status      = STATUS_EMPTY;
                  rsp_in.newest_time = since_ff;
               end else begin
                  remain_in = count_ff;
                  state_in  = ST_DRAIN;
               end
            end else begin
               rsp_valid_in = 1'b1;
               priority if (filtered) begin
                  rsp_in.status = STATUS_FILTERED;
               end else if (dup_any) begin
                  rsp_in.status = STATUS_DUPLICATE;
               end else if (reject) begin
                  rsp_in.status = STATUS_FULL;
               end else begin
                  rsp_in.status = STATUS_INSERTED;
                  cell_op       = CELL_INS;
                  if (count_ff < cap_ff) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end
         end
         ST_DRAIN: begin
            cell_op              = CELL_SHIFT;
            rsp_valid_in         = 1'b1;
            rsp_in.status        = STATUS_DRAINED;
            rsp_in.out_timestamp = cell_entry[0].stamp;
            rsp_in.out_id_word0  = out_words[0];
            rsp_in.out_id_word1  = out_words[1];
            rsp_in.out_id_word2  = out_words[2];
            rsp_in.out_id_word3  = out_words[3];
            rsp_in.out_tag       = cell_entry[0].tag;
            rsp_in.newest_time   = newest_ff;
            rsp_in.last          = (remain_ff == CNT_W'(1));
            remain_in            = remain_ff - CNT_W'(1);
            if (remain_ff == CNT_W'(1)) begin
               count_in = '0;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_valid) begin
         unique case (csr_index)
            CSR_SINCE_TIME: begin
               since_in = csr_wdata;
            end
            CSR_CAPACITY: begin
               cap_in = cap_eff;
               if (count_ff > cap_eff) begin
                  count_in = cap_eff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cap_ff       <= CNT_W'(CAP_RESET);
         since_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cap_ff       <= cap_in;
         since_ff     <= since_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      remain_ff <= remain_in;
      newest_ff <= newest_in;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cap_ff)
      else $error("entry count exceeds capacity");

   a_unique_ids: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> $onehot0(dup_vec))
      else $error("held ids are not unique");

   a_drain_remain: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN) |-> (remain_ff != '0))
      else $error("drain running with nothing left");

   a_accept_cmp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_CMP))
      else $error("accepted word did not enter compare");

   a_offer_one: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_ff.status != STATUS_DRAINED)) |-> rsp_ff.last)
      else $error("single result without last");

endmodule
